### hw/rtl/ttl_pkg.sv
// Shared types and constants for the lockless transposition table.
package ttl_pkg;

    // Request opcodes
    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_PROBE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Bound kinds
    localparam logic [1:0] BK_UPPER = 2'd0;
    localparam logic [1:0] BK_LOWER = 2'd1;
    localparam logic [1:0] BK_EXACT = 2'd2;
    localparam logic [1:0] BK_NONE  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_AGE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATE_THRESHOLD = 1'd1;

    localparam logic [7:0]  AGE_RESET = 8'd0;
    localparam logic [14:0] THR_RESET = 15'd29000;

    localparam int SCORE_OFFSET = 32768;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [63:0]        pos_key;
        logic [24:0]        move_in;
        logic signed [15:0] score_in;
        logic [1:0]         bound_kind;
        logic [5:0]         search_depth;
        logic signed [15:0] window_low;
        logic signed [15:0] window_high;
        logic [5:0]         ply;
    } t_req;

    typedef struct packed {
        logic               key_found;
        logic [24:0]        move_out;
        logic signed [15:0] score_out;
        logic               cutoff;
        logic               stored;
        logic [31:0]        hit_total;
        logic [31:0]        new_write_total;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_req;

    // One table slot as held in memory; the packed data word is rebuilt from it
    typedef struct packed {
        logic [63:0] check;
        logic [7:0]  age;
        logic [24:0] move;
        logic [1:0]  kind;
        logic [5:0]  depth;
        logic [15:0] score_enc;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic   we;
        t_entry ent;
    } t_wr;

endpackage

### hw/rtl/ttl_if.sv
// Valid/ready channel interfaces for requests, results and configuration writes.
interface ttl_req_if import ttl_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ttl_rsp_if import ttl_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ttl_cfg_if import ttl_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/transposition_table_lockless.sv
// Top level of the lockless transposition table: sequencer, slot memory, counters.
// Store/probe: accept, then execute; when TABLE_ENTRIES is a power of two the slot memory is
// read at accept (mask index) and written back in the execute state; otherwise the 64-bit key
// is first reduced in the index unit, and the slot is then read from the captured index.
// Clear: a memory sweep (one slot per cycle), then the result.
// Reset: synchronous; a clearing pass follows, requests wait, config writes are taken
// throughout. Results sit in an output register; execute waits while a result is stalled.
module transposition_table_lockless import ttl_pkg::*; #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ttl_req_if.sink      i_req,
    ttl_rsp_if.source    o_rsp,
    ttl_cfg_if.sink      i_cfg
);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam bit POW2  = (TABLE_ENTRIES == (1 << IDX_W));
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INDEX = 5'b00010,
        S_READ  = 5'b00100,
        S_EXEC  = 5'b01000,
        S_SWEEP = 5'b10000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    t_req             r_req;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_clr_addr;
    logic             r_sweep_report;
    logic [7:0]       r_age;
    logic [14:0]      r_thr;
    logic [31:0]      r_hits;
    logic [31:0]      r_news;
    t_rsp             r_out;
    logic             r_out_valid;

    logic             req_acc;
    logic             cfg_acc;
    logic             exec_go;
    logic             sweep_last;
    logic             idx_start;
    logic             idx_done;
    logic [IDX_W-1:0] idx_val;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_wdata;
    t_entry           ram_rdata;
    t_rsp             ev_rsp;
    t_wr              ev_wr;
    logic [31:0]      ev_hits;
    logic [31:0]      ev_news;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign req_acc    = i_req.valid && i_req.ready;
    assign cfg_acc    = i_cfg.valid && i_cfg.ready;
    assign exec_go    = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);
    assign sweep_last = (r_clr_addr == LAST_IDX);
    assign idx_start  = req_acc && (i_req.data.opcode != OP_CLEAR);

    ttl_index #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (idx_start),
        .i_key   (i_req.data.pos_key),
        .o_idx   (idx_val),
        .o_done  (idx_done)
    );

    // read at accept (mask index) or from the captured index; held through execute
    assign ram_raddr = (r_state == S_IDLE) ? idx_val : r_idx;
    assign ram_we    = (r_state == S_SWEEP) || (exec_go && ev_wr.we);
    assign ram_waddr = (r_state == S_SWEEP) ? r_clr_addr : r_idx;
    assign ram_wdata = (r_state == S_SWEEP) ? '0 : ev_wr.ent;

    ttl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ttl_eval u_eval (
        .i_req     (r_req),
        .i_ent     (ram_rdata),
        .i_age     (r_age),
        .i_thr     (r_thr),
        .i_hits    (r_hits),
        .i_news    (r_news),
        .o_rsp     (ev_rsp),
        .o_wr      (ev_wr),
        .o_hits_nx (ev_hits),
        .o_news_nx (ev_news)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.data.opcode == OP_CLEAR) begin
                        n_state = S_SWEEP;
                    end else if (POW2) begin
                        n_state = S_EXEC;
                    end else begin
                        n_state = S_INDEX;
                    end
                end
            end
            S_INDEX: begin
                if (idx_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (sweep_last) begin
                    n_state = r_sweep_report ? S_EXEC : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_SWEEP;
            r_clr_addr     <= '0;
            r_sweep_report <= 1'b0;
            r_age          <= AGE_RESET;
            r_thr          <= THR_RESET;
            r_hits         <= '0;
            r_news         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_acc) begin
                if (i_cfg.data.reg_index == CFG_CURRENT_AGE) begin
                    r_age <= i_cfg.data.wdata[7:0];
                end else if (i_cfg.data.reg_index == CFG_MATE_THRESHOLD) begin
                    r_thr <= i_cfg.data.wdata;
                end
            end

            if (req_acc && (i_req.data.opcode == OP_CLEAR)) begin
                r_clr_addr     <= '0;
                r_sweep_report <= 1'b1;
                r_age          <= AGE_RESET;
                r_hits         <= '0;
                r_news         <= '0;
            end else if (r_state == S_SWEEP) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end

            if (exec_go) begin
                r_hits      <= ev_hits;
                r_news      <= ev_news;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req <= i_req.data;
            r_idx <= idx_val;
        end else if ((r_state == S_INDEX) && idx_done) begin
            r_idx <= idx_val;
        end
        if (exec_go) begin
            // clear and no-op requests report zeros with the totals
            r_out <= ev_rsp;
        end
    end
endmodule

### hw/rtl/ttl_ram.sv
// Generic simple dual-port RAM with registered read.
module ttl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/ttl_index.sv
// Slot index unit: key modulo table size, a mask or a radix-4 reduction.
module ttl_index #(
    parameter int ENTRIES = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [63:0]                i_key,
    output logic [$clog2(ENTRIES)-1:0] o_idx,
    output logic                       o_done
);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam bit POW2  = (ENTRIES == (1 << IDX_W));

    generate
        if (POW2) begin : g_mask
            assign o_idx  = i_key[IDX_W-1:0];
            assign o_done = i_start;
        end else begin : g_reduce
            localparam logic [IDX_W+1:0] N1 = (IDX_W+2)'(ENTRIES);
            localparam logic [IDX_W+1:0] N2 = (IDX_W+2)'(2 * ENTRIES);
            localparam logic [IDX_W+1:0] N3 = (IDX_W+2)'(3 * ENTRIES);

            logic [IDX_W-1:0] r_rem;
            logic [63:0]      r_key;
            logic [4:0]       r_cnt;
            logic             r_busy;
            logic             r_done;
            logic [IDX_W+1:0] step;
            logic [IDX_W+1:0] n_rem;

            // remainder stays below ENTRIES; two key bits folded in per cycle
            always_comb begin
                step = {r_rem, r_key[63:62]};
                if (step >= N3) begin
                    n_rem = step - N3;
                end else if (step >= N2) begin
                    n_rem = step - N2;
                end else if (step >= N1) begin
                    n_rem = step - N1;
                end else begin
                    n_rem = step;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_cnt  <= '0;
                    end else if (r_busy) begin
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == 5'd31) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= '0;
                    r_key <= i_key;
                end else if (r_busy) begin
                    r_rem <= n_rem[IDX_W-1:0];
                    r_key <= {r_key[61:0], 2'b00};
                end
            end

            assign o_idx  = r_rem;
            assign o_done = r_done;
        end
    endgenerate
endmodule

### hw/rtl/ttl_eval.sv
// Store and probe evaluation on one table slot: replacement, mate adjust, clamping.
module ttl_eval import ttl_pkg::*; (
    input  t_req        i_req,
    input  t_entry      i_ent,
    input  logic [7:0]  i_age,
    input  logic [14:0] i_thr,
    input  logic [31:0] i_hits,
    input  logic [31:0] i_news,
    output t_rsp        o_rsp,
    output t_wr         o_wr,
    output logic [31:0] o_hits_nx,
    output logic [31:0] o_news_nx
);
    localparam logic [15:0]        SCORE_OFS_LO = 16'(SCORE_OFFSET);
    localparam logic signed [17:0] SCORE_OFS_S  = 18'(SCORE_OFFSET);

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] pack_data(input logic [15:0] enc, input logic [5:0] depth,
                                              input logic [1:0] kind, input logic [24:0] mv);
        return {14'd0, mv, kind, 1'b0, depth, enc};
    endfunction

    logic               is_store;
    logic               is_probe;
    logic [63:0]        data_old;
    logic [63:0]        data_new;
    logic               empty;
    logic               match;
    logic               sufficient;
    logic               replace;
    logic signed [17:0] thr_s;
    logic signed [17:0] ply_s;
    logic signed [17:0] st_sc;
    logic signed [17:0] st_adj;
    logic signed [15:0] st_sat;
    logic [15:0]        st_enc;
    logic signed [17:0] pr_sc;
    logic signed [17:0] pr_adj;
    logic signed [15:0] pr_sat;
    logic signed [15:0] pr_out;
    logic               pr_cut;

    assign is_store = (i_req.opcode == OP_STORE);
    assign is_probe = (i_req.opcode == OP_PROBE);
    assign thr_s    = {3'b000, i_thr};
    assign ply_s    = {12'd0, i_req.ply};

    assign data_old   = pack_data(i_ent.score_enc, i_ent.depth, i_ent.kind, i_ent.move);
    assign empty      = (i_ent.check == 64'd0);
    assign match      = (i_ent.check == (i_req.pos_key ^ data_old));
    assign sufficient = match && (i_ent.depth >= i_req.search_depth);
    assign replace    = empty || (i_ent.age < i_age) || (i_ent.depth <= i_req.search_depth);

    // store path: mate scores pushed away from zero by ply
    always_comb begin
        st_sc = {{2{i_req.score_in[15]}}, i_req.score_in};
        if (st_sc > thr_s) begin
            st_adj = st_sc + ply_s;
        end else if (st_sc < -thr_s) begin
            st_adj = st_sc - ply_s;
        end else begin
            st_adj = st_sc;
        end
    end

    assign st_sat   = sat16(st_adj);
    assign st_enc   = st_sat + SCORE_OFS_LO;
    assign data_new = pack_data(st_enc, i_req.search_depth, i_req.bound_kind, i_req.move_in);

    always_comb begin
        o_wr.we            = is_store && replace;
        o_wr.ent.check     = i_req.pos_key ^ data_new;
        o_wr.ent.age       = i_age;
        o_wr.ent.move      = i_req.move_in;
        o_wr.ent.kind      = i_req.bound_kind;
        o_wr.ent.depth     = i_req.search_depth;
        o_wr.ent.score_enc = st_enc;
    end

    // probe path: mate scores pulled back by ply, then clamped by bound kind
    always_comb begin
        pr_sc = $signed({2'b00, i_ent.score_enc}) - SCORE_OFS_S;
        if (pr_sc > thr_s) begin
            pr_adj = pr_sc - ply_s;
        end else if (pr_sc < -thr_s) begin
            pr_adj = pr_sc + ply_s;
        end else begin
            pr_adj = pr_sc;
        end
    end

    assign pr_sat = sat16(pr_adj);

    always_comb begin
        pr_out = pr_sat;
        pr_cut = 1'b0;
        case (i_ent.kind)
            BK_UPPER: begin
                if (pr_sat <= i_req.window_low) begin
                    pr_out = i_req.window_low;
                    pr_cut = 1'b1;
                end
            end
            BK_LOWER: begin
                if (pr_sat >= i_req.window_high) begin
                    pr_out = i_req.window_high;
                    pr_cut = 1'b1;
                end
            end
            BK_EXACT: pr_cut = 1'b1;
            default:  pr_cut = 1'b0;
        endcase
    end

    assign o_hits_nx = (is_probe && sufficient && (i_hits != '1)) ? i_hits + 32'd1 : i_hits;
    assign o_news_nx = (is_store && empty && (i_news != '1)) ? i_news + 32'd1 : i_news;

    always_comb begin
        o_rsp.key_found       = is_probe && match;
        o_rsp.move_out        = (is_probe && match) ? i_ent.move : 25'd0;
        o_rsp.score_out       = (is_probe && sufficient) ? pr_out : 16'sd0;
        o_rsp.cutoff          = is_probe && sufficient && pr_cut;
        o_rsp.stored          = is_store && replace;
        o_rsp.hit_total       = o_hits_nx;
        o_rsp.new_write_total = o_news_nx;
    end
endmodule

### hw/rtl/ttl_checker.sv
// Port-level checker for the lockless transposition table, bound to the top level.
module ttl_checker import ttl_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp_data
);
    logic [1:0] r_pend;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_req_valid && i_req_ready;
    assign out_acc = i_rsp_valid && i_rsp_ready;

    // requests accepted whose result has not been taken yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (r_pend != 2'd0))
        else $error("result with no request outstanding");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two requests outstanding");

    a_sweep_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_req_ready)
        else $error("request taken before the clearing pass");

    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_data.key_found) |->
            (i_rsp_data.move_out == 25'd0) && !i_rsp_data.cutoff
            && (i_rsp_data.score_out == 16'sd0))
        else $error("probe fields set without a key match");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled result changed");
endmodule

bind transposition_table_lockless ttl_checker u_ttl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

### bench/tb_transposition_table_lockless.sv
// Self-checking testbench for the lockless transposition table: directed and random requests.
`timescale 1ns / 1ps

module tb_transposition_table_lockless;
    import ttl_pkg::*;

    localparam int TABLE_ENTRIES = 4096;
    localparam int HOT_KEYS      = 24;

    logic i_clk;
    logic i_rst_n;

    ttl_req_if req_ch ();
    ttl_rsp_if rsp_ch ();
    ttl_cfg_if cfg_ch ();

    transposition_table_lockless #(.TABLE_ENTRIES(TABLE_ENTRIES)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of the slot memory, counters and registers
    bit [63:0]   slot_data  [TABLE_ENTRIES];
    bit [63:0]   slot_check [TABLE_ENTRIES];
    bit [7:0]    slot_age   [TABLE_ENTRIES];
    bit [31:0]   hit_tally;
    bit [31:0]   new_slot_tally;
    logic [7:0]  age_now  = AGE_RESET;
    logic [14:0] mate_thr = THR_RESET;

    t_rsp        pending_results [$];
    logic [63:0] hot_keys [HOT_KEYS];

    int mismatch_count;
    int n_store, n_probe, n_clear, n_other, n_checked, n_cutoff, n_found;

    int tx_gap_max;
    int tx_burst_left;
    int rx_mode;
    int rx_hold_cycles;
    int rx_run;
    bit rx_level;

    function automatic bit [31:0] bump(bit [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function automatic int sat_score(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Applies one request to the shadow table and returns the result it must produce
    function automatic t_rsp table_predict(t_req r);
        t_rsp        res;
        int unsigned slot;
        logic [63:0] word;
        logic [15:0] enc;
        int          sc, thr, ply, alpha, beta;
        bit          take;
        res   = '0;
        slot  = int'(r.pos_key % TABLE_ENTRIES);
        thr   = int'(mate_thr);
        ply   = int'(r.ply);
        alpha = int'($signed(r.window_low));
        beta  = int'($signed(r.window_high));
        case (r.opcode)
            OP_STORE: begin
                take = 1'b0;
                if (slot_check[slot] == '0) begin
                    new_slot_tally = bump(new_slot_tally);
                    take = 1'b1;
                end else if (slot_age[slot] < age_now) begin
                    take = 1'b1;
                end else if (slot_data[slot][21:16] <= r.search_depth) begin
                    take = 1'b1;
                end
                if (take) begin
                    sc = int'($signed(r.score_in));
                    // mate distances grow by ply going into the table
                    if (sc > thr) sc += ply;
                    else if (sc < -thr) sc -= ply;
                    sc   = sat_score(sc);
                    enc  = 16'(sc + SCORE_OFFSET);
                    word = {14'd0, r.move_in, r.bound_kind, 1'b0, r.search_depth, enc};
                    slot_age[slot]   = age_now;
                    slot_data[slot]  = word;
                    slot_check[slot] = r.pos_key ^ word;
                    res.stored = 1'b1;
                end
            end
            OP_PROBE: begin
                word = slot_data[slot];
                if (slot_check[slot] == (r.pos_key ^ word)) begin
                    res.key_found = 1'b1;
                    res.move_out  = word[49:25];
                    if (word[21:16] >= r.search_depth) begin
                        sc = int'({16'd0, word[15:0]}) - SCORE_OFFSET;
                        hit_tally = bump(hit_tally);
                        if (sc > thr) sc -= ply;
                        else if (sc < -thr) sc += ply;
                        sc = sat_score(sc);
                        case (word[24:23])
                            BK_UPPER: begin
                                if (sc <= alpha) begin
                                    sc = alpha;
                                    res.cutoff = 1'b1;
                                end
                            end
                            BK_LOWER: begin
                                if (sc >= beta) begin
                                    sc = beta;
                                    res.cutoff = 1'b1;
                                end
                            end
                            BK_EXACT: res.cutoff = 1'b1;
                            default: ;
                        endcase
                        res.score_out = 16'(sc);
                    end
                end
            end
            OP_CLEAR: begin
                foreach (slot_data[i]) begin
                    slot_data[i]  = '0;
                    slot_check[i] = '0;
                    slot_age[i]   = '0;
                end
                hit_tally      = '0;
                new_slot_tally = '0;
                age_now        = '0;
            end
            default: ;
        endcase
        res.hit_total       = hit_tally;
        res.new_write_total = new_slot_tally;
        return res;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic check_result(t_rsp got);
        t_rsp want;
        if (pending_results.size() == 0) begin
            $error("result arrived with no request outstanding");
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        n_checked++;
        check_field("key_found", want.key_found, got.key_found);
        check_field("move_out", want.move_out, got.move_out);
        check_field("score_out", want.score_out, got.score_out);
        check_field("cutoff", want.cutoff, got.cutoff);
        check_field("stored", want.stored, got.stored);
        check_field("hit_total", want.hit_total, got.hit_total);
        check_field("new_write_total", want.new_write_total, got.new_write_total);
    endtask

    // Register writes, request predictions and result checks, all at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.data.reg_index)
                    CFG_CURRENT_AGE:    age_now  = cfg_ch.data.wdata[7:0];
                    CFG_MATE_THRESHOLD: mate_thr = cfg_ch.data.wdata[14:0];
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready) begin
                case (req_ch.data.opcode)
                    OP_STORE: n_store++;
                    OP_PROBE: n_probe++;
                    OP_CLEAR: n_clear++;
                    default:  n_other++;
                endcase
                pending_results.push_back(table_predict(req_ch.data));
                if (pending_results[$].cutoff) n_cutoff++;
                if (pending_results[$].key_found) n_found++;
            end
            if (rsp_ch.valid && rsp_ch.ready) check_result(rsp_ch.data);
        end
    end

    // Result receiver: own stall pattern, plus a counted hold-off on request
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp_ch.ready <= 1'b0;
            end else if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        if (rx_run == 0) begin
                            rx_run   = $urandom_range(1, 10);
                            rx_level = ~rx_level;
                        end
                        rx_run--;
                        rsp_ch.ready <= rx_level;
                    end
                endcase
            end
        end
    end

    task automatic send_request(t_req r);
        int gap;
        if (tx_gap_max > 0 && tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, tx_gap_max);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (tx_burst_left > 0) tx_burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            mismatch_count++;
            pending_results.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(logic [14:0] age_word, logic [14:0] thr_word);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{reg_index: CFG_CURRENT_AGE, wdata: age_word};
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.data  <= '{reg_index: CFG_MATE_THRESHOLD, wdata: thr_word};
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_req make_req(logic [1:0] op, logic [63:0] key, logic [24:0] mv,
                                      int sc, logic [1:0] kind, int depth, int lo, int hi,
                                      int ply);
        t_req r;
        r.opcode       = op;
        r.pos_key      = key;
        r.move_in      = mv;
        r.score_in     = 16'(sc);
        r.bound_kind   = kind;
        r.search_depth = 6'(depth);
        r.window_low   = 16'(lo);
        r.window_high  = 16'(hi);
        r.ply          = 6'(ply);
        return r;
    endfunction

    // Mostly stores and probes on a few crowded slots so probes hit and slots get contested
    function automatic t_req random_request(bit with_clear);
        t_req r;
        int   pick, mag, v;
        pick = $urandom_range(0, 199);
        if (with_clear && pick == 0) r.opcode = OP_CLEAR;
        else if (pick < 4) r.opcode = OP_NOP;
        else if (pick < 100) r.opcode = OP_STORE;
        else r.opcode = OP_PROBE;

        pick = $urandom_range(0, 99);
        if (pick < 75) r.pos_key = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
        else if (pick < 80) r.pos_key = '0;
        else r.pos_key = {$urandom, $urandom};

        r.move_in = 25'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            // around the mate threshold, both signs
            mag = int'(mate_thr) + int'($urandom_range(0, 80)) - 40;
            if (mag < 0) mag = 0;
            if (mag > 32767) mag = 32767;
            v = $urandom_range(0, 1) ? -mag : mag;
        end else if (pick < 45) begin
            v = int'($urandom_range(0, 65535)) - 32768;
        end else if (pick < 70) begin
            v = int'($urandom_range(0, 400)) - 200;
        end else begin
            v = int'($urandom_range(0, 64000)) - 32000;
        end
        r.score_in = 16'(v);

        r.bound_kind   = 2'($urandom);
        r.search_depth = $urandom_range(0, 1) ? 6'($urandom_range(0, 12)) : 6'($urandom);
        v = int'($urandom_range(0, 64000)) - 32000;
        r.window_low = 16'(v);
        v = int'($urandom_range(0, 64000)) - 32000;
        r.window_high = 16'(v);
        r.ply = 6'($urandom);
        return r;
    endfunction

    task automatic test_empty_table();
        // key zero matches an untouched slot; any other key misses
        send_request(make_req(OP_PROBE, 64'd0, 0, 0, BK_UPPER, 0, -100, 100, 5));
        send_request(make_req(OP_PROBE, 64'd0, 0, 0, BK_UPPER, 1, -100, 100, 5));
        send_request(make_req(OP_PROBE, 64'hFFFF_FFFF_FFFF_F000, 0, 0, BK_UPPER, 0, 0, 0, 0));
    endtask

    task automatic test_store_probe_rules();
        logic [63:0] k1, k2, k3, k7, k8;
        k1 = 64'hDEAD_BEEF_0000_0001;
        k2 = 64'h0123_4567_89AB_C002;
        k3 = 64'hFFFF_FFFF_FFFF_F003;
        k7 = 64'h8000_0000_0000_0007;
        k8 = 64'h5555_AAAA_5555_A008;
        send_request(make_req(OP_STORE, k1, 25'h1FFFFFF, 30000, BK_EXACT, 10, 0, 0, 7));
        send_request(make_req(OP_PROBE, k1, 0, 0, BK_UPPER, 10, -100, 100, 3));
        // shallower store loses, equal depth replaces
        send_request(make_req(OP_STORE, k1, 25'h0AAAAAA, 0, BK_UPPER, 9, 0, 0, 0));
        send_request(make_req(OP_STORE, k1, 25'h1555555, -30000, BK_LOWER, 10, 0, 0, 63));
        send_request(make_req(OP_PROBE, k1, 0, 0, BK_UPPER, 63, 0, 0, 0));
        send_request(make_req(OP_PROBE, k1, 0, 0, BK_UPPER, 0, 0, -32000, 63));
        send_request(make_req(OP_PROBE, k1, 0, 0, BK_UPPER, 0, 0, 0, 63));
        send_request(make_req(OP_STORE, k2, 0, 100, BK_UPPER, 63, 0, 0, 0));
        send_request(make_req(OP_PROBE, k2, 0, 0, BK_UPPER, 63, 200, 300, 0));
        send_request(make_req(OP_PROBE, k2, 0, 0, BK_UPPER, 5, -32000, 32000, 0));
        send_request(make_req(OP_STORE, k3, 25'h1234567, -5, BK_NONE, 20, 0, 0, 0));
        send_request(make_req(OP_PROBE, k3, 0, 0, BK_UPPER, 20, -32000, 32000, 0));
        // stored score saturates at both ends
        send_request(make_req(OP_STORE, k7, 25'h1000000, 32767, BK_EXACT, 1, 0, 0, 63));
        send_request(make_req(OP_PROBE, k7, 0, 0, BK_UPPER, 1, 0, 0, 0));
        send_request(make_req(OP_STORE, k8, 25'h0000001, -32768, BK_EXACT, 2, 0, 0, 63));
        send_request(make_req(OP_PROBE, k8, 0, 0, BK_UPPER, 2, 0, 0, 63));
        send_request(make_req(OP_PROBE, k1 ^ 64'h0000_0100_0000_0000, 0, 0, BK_UPPER, 0,
                              0, 0, 0));
        send_request(make_req(OP_NOP, k1, 25'h1FFFFFF, -1, BK_NONE, 63, -1, -1, 63));
        send_request(make_req(OP_STORE, 64'd0, 25'h1ABCDEF, 123, BK_LOWER, 0, 0, 0, 0));
        send_request(make_req(OP_PROBE, 64'd0, 0, 0, BK_UPPER, 0, -32000, 32000, 0));
        send_request(make_req(OP_CLEAR, 64'd0, 0, 0, BK_UPPER, 0, 0, 0, 0));
        send_request(make_req(OP_PROBE, k1, 0, 0, BK_UPPER, 0, -32000, 32000, 0));
        send_request(make_req(OP_PROBE, 64'd0, 0, 0, BK_UPPER, 0, -32000, 32000, 0));
    endtask

    task automatic test_age_replacement();
        logic [63:0] k5;
        k5 = 64'h0F0F_F0F0_1234_5005;
        set_config(15'd5, 15'd29000);
        send_request(make_req(OP_STORE, k5, 25'h0000ABC, 500, BK_EXACT, 40, 0, 0, 0));
        // a newer generation replaces regardless of depth
        set_config(15'd6, 15'd29000);
        send_request(make_req(OP_STORE, k5, 25'h0000DEF, 600, BK_EXACT, 1, 0, 0, 0));
        send_request(make_req(OP_STORE, k5, 25'h0000123, 700, BK_EXACT, 0, 0, 0, 0));
        send_request(make_req(OP_PROBE, k5, 0, 0, BK_UPPER, 0, 0, 0, 0));
        // upper bits of the age write are dropped; threshold zero adjusts every nonzero score
        set_config(15'h7FFF, 15'd0);
        send_request(make_req(OP_STORE, k5, 25'h1111111, 1, BK_LOWER, 0, 0, 0, 9));
        send_request(make_req(OP_PROBE, k5, 0, 0, BK_UPPER, 0, 0, 32000, 4));
        send_request(make_req(OP_STORE, k5 + 64'h1000, 25'h0, 0, BK_EXACT, 3, 0, 0, 9));
        send_request(make_req(OP_PROBE, k5 + 64'h1000, 0, 0, BK_UPPER, 3, 0, 0, 9));
        send_request(make_req(OP_CLEAR, 64'd0, 0, 0, BK_UPPER, 0, 0, 0, 0));
        send_request(make_req(OP_STORE, k5, 25'h0, -29500, BK_UPPER, 7, 0, 0, 11));
        send_request(make_req(OP_PROBE, k5, 0, 0, BK_UPPER, 7, -29000, 0, 2));
    endtask

    task automatic test_config_sweep();
        logic [14:0] ages [5] = '{15'd0, 15'd255, 15'd17, 15'd200, 15'd128};
        logic [14:0] thrs [5] = '{15'd0, 15'd32767, 15'd100, 15'd29000, 15'd31990};
        int          gaps [5] = '{0, 3, 8, 2, 5};
        int          modes [5] = '{0, 1, 2, 1, 2};
        for (int p = 0; p < 5; p++) begin
            set_config(ages[p], thrs[p]);
            tx_gap_max = gaps[p];
            rx_mode    = modes[p];
            repeat (120) send_request(random_request(1'b1));
        end
    endtask

    task automatic test_random_bulk();
        set_config(15'd3, 15'd29000);
        tx_gap_max = 6;
        rx_mode    = 2;
        repeat (430) send_request(random_request(1'b1));
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        tx_gap_max     = 0;
        rx_mode        = 1;
        rx_hold_cycles = 300;
        repeat (40) send_request(random_request(1'b0));
    endtask

    initial begin
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        i_rst_n      <= 1'b0;
        tx_gap_max     = 0;
        tx_burst_left  = 0;
        rx_mode        = 0;
        rx_hold_cycles = 0;
        rx_run         = 0;
        rx_level       = 1'b0;
        for (int i = 0; i < HOT_KEYS; i++) begin
            hot_keys[i] = {$urandom, $urandom};
            hot_keys[i][11:0] = 12'((i % 6) * 683 + 1);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_store_probe_rules();
        test_age_replacement();
        test_config_sweep();
        test_random_bulk();
        test_output_backpressure();
        wait_idle();

        $display("Sent %0d stores, %0d probes, %0d clears, %0d no-ops across six phases.",
                 n_store, n_probe, n_clear, n_other);
        $display("Checked %0d results: %0d key matches, %0d cutoffs.",
                 n_checked, n_found, n_cutoff);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
